// ----- rtl/general_matrix_multiply_macros.svh -----
// assertion macros for the general matrix multiply block
// included by the top level; no other dependencies
`ifndef GENERAL_MATRIX_MULTIPLY_MACROS_SVH
`define GENERAL_MATRIX_MULTIPLY_MACROS_SVH

// same-cycle implication, disabled during reset
`define GMM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define GMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gmm_pkg.sv -----
// shared types, constants and fixed-point helpers of the matrix multiply block
// no dependencies
package gmm_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 3;
    localparam int DIM_W       = 4;
    localparam int CFG_IDX_W   = 3;

    // action codes
    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_LOAD_C = 2'd2;
    localparam logic [1:0] ACT_START  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_M    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_N    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_K   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BETA      = 3'd5;

    typedef struct packed {
        logic [1:0]                action;
        logic [POS_W-1:0]          row_index;
        logic [POS_W-1:0]          col_index;
        logic signed [VALUE_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]          out_row;
        logic [POS_W-1:0]          out_col;
        logic signed [VALUE_W-1:0] out_value;
        logic                      last_element;
    } t_out_item;

    // classified transaction handed from front to engine
    typedef struct packed {
        logic                      is_start;
        logic                      wr_a;
        logic                      wr_b;
        logic                      wr_c;
        logic [POS_W-1:0]          row;
        logic [POS_W-1:0]          col;
        logic [VALUE_W-1:0]        value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]                transpose_mode;
        logic [DIM_W-1:0]          rows_m;
        logic [DIM_W-1:0]          cols_n;
        logic [DIM_W-1:0]          inner_k;
        logic signed [VALUE_W-1:0] alpha_scale;
        logic signed [VALUE_W-1:0] beta_scale;
    } t_cfg;

    typedef struct packed {
        logic idle;
        logic cmd_pop;
        logic res_push;
        logic res_last;
    } t_eng_status;

    localparam t_cfg CFG_RESET = '{
        transpose_mode: 2'd0,
        rows_m:         4'd8,
        cols_n:         4'd8,
        inner_k:        4'd8,
        alpha_scale:    32'sd65536,
        beta_scale:     32'sd0
    };

    // 64-bit add that saturates at the signed limits
    function automatic logic signed [63:0] f_sat_add64(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

    // shift right by 16 toward minus infinity, saturate to 32 bits
    function automatic logic signed [31:0] f_shift_sat32(input logic signed [63:0] x);
        logic [47:0] y;
        logic [31:0] r;
        y = x[63:16];
        if (!y[47] && (|y[46:31])) begin
            r = {1'b0, {31{1'b1}}};
        end else if (y[47] && !(&y[46:31])) begin
            r = {1'b1, 31'd0};
        end else begin
            r = y[31:0];
        end
        return $signed(r);
    endfunction

endpackage

// ----- rtl/gmm_ram.sv -----
// generic single write, single read port ram with registered read data
// depends on gmm_pkg for default width
module gmm_ram #(
    parameter int WIDTH = gmm_pkg::VALUE_W,
    parameter int DEPTH = gmm_pkg::MAX_DIM_DEF * gmm_pkg::MAX_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- rtl/gmm_fifo.sv -----
// two-entry queue for any packed payload type
// no package dependencies
module gmm_fifo #(
    parameter type t_data = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);
    t_data      r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end
endmodule

// ----- rtl/gmm_front.sv -----
// front end: accepts input transactions, classifies them, queues them
// depends on gmm_pkg and gmm_fifo
module gmm_front #(
    parameter int MAX_DIM = gmm_pkg::MAX_DIM_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gmm_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_cmd_pop,
    output gmm_pkg::t_cmd     o_cmd,
    output logic              o_cmd_empty
);
    import gmm_pkg::*;

    t_cmd cmd;
    logic in_range;

    // loads outside the stores are dropped here
    assign in_range = ({1'b0, i_item.row_index} < DIM_W'(MAX_DIM)) &&
                      ({1'b0, i_item.col_index} < DIM_W'(MAX_DIM));

    always_comb begin
        cmd.is_start = (i_item.action == ACT_START);
        cmd.wr_a     = (i_item.action == ACT_LOAD_A) && in_range;
        cmd.wr_b     = (i_item.action == ACT_LOAD_B) && in_range;
        cmd.wr_c     = (i_item.action == ACT_LOAD_C) && in_range;
        cmd.row      = i_item.row_index;
        cmd.col      = i_item.col_index;
        cmd.value    = i_item.element_value;
    end

    gmm_fifo #(.t_data(t_cmd)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );
endmodule

// ----- rtl/gmm_engine.sv -----
// back end: executes loads and runs the multiply-accumulate walk over C
// depends on gmm_pkg and gmm_ram
module gmm_engine #(
    parameter int MAX_DIM = gmm_pkg::MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gmm_pkg::t_cfg        i_cfg,
    input  gmm_pkg::t_cmd        i_cmd,
    input  logic                 i_cmd_empty,
    output logic                 o_cmd_pop,
    input  logic                 i_res_full,
    output logic                 o_res_push,
    output gmm_pkg::t_out_item   o_res,
    output gmm_pkg::t_eng_status o_status
);
    import gmm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MAC   = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_SCALE = 6'b001000,
        ST_SUM   = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [DIM_W-1:0] r_i, n_i, r_j, n_j, r_p, n_p;
    logic r_rd_v, r_mul_v;
    logic signed [63:0] r_prod, r_acc, n_acc, r_pa, r_pb;
    logic signed [31:0] r_dot, r_res;

    logic [DIM_W-1:0] dim_m, dim_n, dim_k;
    logic ta, tb, issue, drained, last, emit_go;
    logic [AW-1:0] a_rd_addr, b_rd_addr, c_rd_addr;
    logic [AW-1:0] load_addr;
    logic [VALUE_W-1:0] a_rd_data, b_rd_data, c_rd_data;
    logic c_we;
    logic [AW-1:0] c_wr_addr;
    logic [VALUE_W-1:0] c_wr_data;
    logic start_load;

    function automatic logic [AW-1:0] f_addr(input logic [DIM_W-1:0] r,
                                             input logic [DIM_W-1:0] c);
        return AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    function automatic logic [DIM_W-1:0] f_clamp(input logic [DIM_W-1:0] d);
        return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
    endfunction

    assign dim_m = f_clamp(i_cfg.rows_m);
    assign dim_n = f_clamp(i_cfg.cols_n);
    assign dim_k = f_clamp(i_cfg.inner_k);
    assign ta    = i_cfg.transpose_mode[0];
    assign tb    = i_cfg.transpose_mode[1];

    assign issue     = (r_state == ST_MAC) && (r_p < dim_k);
    assign drained   = !r_rd_v && !r_mul_v;
    assign last      = (r_i == dim_m - 1'b1) && (r_j == dim_n - 1'b1);
    assign emit_go   = (r_state == ST_EMIT) && !i_res_full;
    assign o_cmd_pop = (r_state == ST_IDLE) && !i_cmd_empty;
    assign start_load = o_cmd_pop;

    assign a_rd_addr = ta ? f_addr(r_p, r_i) : f_addr(r_i, r_p);
    assign b_rd_addr = tb ? f_addr(r_j, r_p) : f_addr(r_p, r_j);
    assign c_rd_addr = f_addr(r_i, r_j);
    assign load_addr = f_addr({1'b0, i_cmd.row}, {1'b0, i_cmd.col});

    // store_c is written by loads while idle and by the walk on each emit
    assign c_we      = emit_go || (start_load && i_cmd.wr_c);
    assign c_wr_addr = emit_go ? c_rd_addr : load_addr;
    assign c_wr_data = emit_go ? r_res : i_cmd.value;

    gmm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk(i_clk), .i_we(start_load && i_cmd.wr_a), .i_wr_addr(load_addr),
        .i_wr_data(i_cmd.value), .i_rd_en(issue), .i_rd_addr(a_rd_addr),
        .o_rd_data(a_rd_data)
    );

    gmm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk(i_clk), .i_we(start_load && i_cmd.wr_b), .i_wr_addr(load_addr),
        .i_wr_data(i_cmd.value), .i_rd_en(issue), .i_rd_addr(b_rd_addr),
        .o_rd_data(b_rd_data)
    );

    gmm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_c (
        .i_clk(i_clk), .i_we(c_we), .i_wr_addr(c_wr_addr),
        .i_wr_data(c_wr_data), .i_rd_en((r_state == ST_DRAIN) && drained),
        .i_rd_addr(c_rd_addr), .o_rd_data(c_rd_data)
    );

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_p     = r_p;
        n_acc   = r_mul_v ? f_sat_add64(r_acc, r_prod) : r_acc;
        unique case (r_state)
            ST_IDLE: begin
                if (start_load && i_cmd.is_start) begin
                    n_i   = '0;
                    n_j   = '0;
                    n_p   = '0;
                    n_acc = '0;
                    if (dim_m != '0 && dim_n != '0) begin
                        n_state = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                if (issue) begin
                    n_p = r_p + 1'b1;
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drained) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_go) begin
                    n_p   = '0;
                    n_acc = '0;
                    if (last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_MAC;
                        if (r_i == dim_m - 1'b1) begin
                            n_i = '0;
                            n_j = r_j + 1'b1;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= issue;
            r_mul_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_p    <= n_p;
        r_acc  <= n_acc;
        r_prod <= $signed(a_rd_data) * $signed(b_rd_data);
        if ((r_state == ST_DRAIN) && drained) begin
            r_dot <= f_shift_sat32(r_acc);
        end
        if (r_state == ST_SCALE) begin
            r_pb <= i_cfg.beta_scale * $signed(c_rd_data);
            r_pa <= i_cfg.alpha_scale * r_dot;
        end
        if (r_state == ST_SUM) begin
            r_res <= f_shift_sat32(f_sat_add64(r_pb, r_pa));
        end
    end

    assign o_res_push         = emit_go;
    assign o_res.out_row      = r_i[POS_W-1:0];
    assign o_res.out_col      = r_j[POS_W-1:0];
    assign o_res.out_value    = r_res;
    assign o_res.last_element = last;

    assign o_status.idle     = (r_state == ST_IDLE);
    assign o_status.cmd_pop  = o_cmd_pop;
    assign o_status.res_push = emit_go;
    assign o_status.res_last = last;
endmodule

// ----- rtl/general_matrix_multiply.sv -----
// top level of the scaled matrix multiply-accumulate block (C = beta*C + alpha*op(A)*op(B))
// depends on gmm_pkg, gmm_front, gmm_engine, gmm_fifo and the assertion macro header
//
// Load transactions write one element of A, B or C (Q16.16) in the engine; loads outside
// MAX_DIM are dropped. A start transaction walks C column by column, row by row within a
// column, and emits one result per element with last_element on the final one. For each
// element, with inner_k taken as at most MAX_DIM, the engine issues inner_k reads from the A
// and B rams, sees the end of the inner loop, drains the read and multiply pipeline and then
// reads old C, then does the two scale multiplies, the saturating sum and the write back
// with the emit. The emit cycle repeats while the result queue is full. The front queue
// keeps taking transactions while a walk runs, and a two-entry result queue decouples
// o_item from the engine. The user must see that configuration is written only while the
// block is idle; the block itself does not enforce this.
module general_matrix_multiply #(
    parameter int MAX_DIM = gmm_pkg::MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input transactions
    input  logic                            i_push,
    input  gmm_pkg::t_in_item               i_item,
    output logic                            o_full,
    // result transactions
    input  logic                            i_pop,
    output gmm_pkg::t_out_item              o_item,
    output logic                            o_empty,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [gmm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gmm_pkg::VALUE_W-1:0]     i_cfg_data
);
    import gmm_pkg::*;
    `include "general_matrix_multiply_macros.svh"

    t_cfg        r_cfg, n_cfg;
    t_cmd        cmd;
    logic        cmd_empty, cmd_pop;
    logic        res_full, res_push;
    t_out_item   res;
    t_eng_status status;

    // configuration registers, unknown indexes ignored
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TRANSPOSE: n_cfg.transpose_mode = i_cfg_data[1:0];
                REG_ROWS_M:    n_cfg.rows_m         = i_cfg_data[DIM_W-1:0];
                REG_COLS_N:    n_cfg.cols_n         = i_cfg_data[DIM_W-1:0];
                REG_INNER_K:   n_cfg.inner_k        = i_cfg_data[DIM_W-1:0];
                REG_ALPHA:     n_cfg.alpha_scale    = $signed(i_cfg_data);
                REG_BETA:      n_cfg.beta_scale     = $signed(i_cfg_data);
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front: accept and classify
    gmm_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty)
    );

    // back: stores and arithmetic
    gmm_engine #(.MAX_DIM(MAX_DIM)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res),
        .o_status    (status)
    );

    // result queue toward the consumer
    gmm_fifo #(.t_data(t_out_item)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_empty (o_empty)
    );

    // engine only pushes into a result queue with room
    `GMM_ASSERT_SAME(a_push_room, i_clk, i_rst_n, status.res_push, !res_full, "push while full")
    // commands are taken only between walks
    `GMM_ASSERT_SAME(a_pop_idle, i_clk, i_rst_n, status.cmd_pop, status.idle, "pop during walk")
    // the marked result ends the walk
    `GMM_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, status.res_push && status.res_last, status.idle, "walk past last")
    // a result queued while the queue was empty shows up at the output
    `GMM_ASSERT_NEXT(a_res_visible, i_clk, i_rst_n, res_push && o_empty, !o_empty, "result not visible")
endmodule
